### design/bfmc_pkg.sv
package bfmc_pkg;

    // Field and register widths
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 17;
    localparam int BYTE_W  = 8;
    localparam int FB_W    = 21;
    localparam int HC_W    = 2;
    localparam int HASH_W  = 32;

    // Remainder unit: divisor wide enough for the largest store size in bytes
    localparam int DIV_W   = 25;
    localparam int CNT_W   = 6;
    localparam logic [CNT_W-1:0] MOD_STEPS = CNT_W'(HASH_W);

    // Request commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_KEY   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic CFG_FILTER_BITS = 1'b0;
    localparam logic CFG_HASH_COUNT  = 1'b1;

    localparam logic [FB_W-1:0] FILTER_BITS_RST = 21'd1048576;
    localparam logic [HC_W-1:0] HASH_COUNT_RST  = 2'd2;
    localparam logic [HC_W-1:0] HASH_COUNT_MAX  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_MOD,
        S_HASH_MOD,
        S_BYTE_MOD,
        S_READ,
        S_TEST,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
        logic [DIV_W-1:0]  divisor;
    } t_mod_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] rem;
    } t_mod_rsp;

endpackage

### design/bfmc_in_if.sv
interface bfmc_in_if;
    logic                          valid;
    logic                          ready;
    logic [bfmc_pkg::CMD_W-1:0]    cmd;
    logic [bfmc_pkg::ADDR_W-1:0]   load_addr;
    logic [bfmc_pkg::BYTE_W-1:0]   load_data;
    logic [bfmc_pkg::BYTE_W-1:0]   key_byte;

    modport source (output valid, cmd, load_addr, load_data, key_byte, input ready);
    modport sink   (input valid, cmd, load_addr, load_data, key_byte, output ready);
endinterface

### design/bfmc_out_if.sv
interface bfmc_out_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, found, input ready);
    modport sink   (input valid, found, output ready);
endinterface

### design/bfmc_mod.sv
// Restoring remainder unit, one dividend bit per cycle
module bfmc_mod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bfmc_pkg::t_mod_req  i_req,
    output bfmc_pkg::t_mod_rsp  o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [bfmc_pkg::CNT_W-1:0]     r_cnt;
    logic [bfmc_pkg::DIV_W-1:0]     r_rem;
    logic [bfmc_pkg::HASH_W-1:0]    r_dvd;
    logic [bfmc_pkg::DIV_W-1:0]     r_div;
    logic [bfmc_pkg::DIV_W-1:0]     n_rem;
    logic [bfmc_pkg::DIV_W:0]       trial;
    logic [bfmc_pkg::DIV_W:0]       diff;

    // shift in next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvd[bfmc_pkg::HASH_W-1]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            n_rem = diff[bfmc_pkg::DIV_W-1:0];
        end else begin
            n_rem = trial[bfmc_pkg::DIV_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= bfmc_pkg::MOD_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == bfmc_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[bfmc_pkg::HASH_W-2:0], 1'b0};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

### design/bloom_filter_membership_check_core.sv
// Bloom filter lookup engine.
// Requests arrive on i_req (valid/ready): cmd selects a filter byte load,
// a key byte, or end of key. Nonzero key bytes update the SAX and SDBM
// hashes; a zero key byte is ignored. A load writes the store directly when
// MAX_FILTER_BYTES is a power of two, otherwise it first wraps the address
// through the remainder unit. End of key gives one result on o_res: found
// is 1 only if every tested filter bit is set. Each tested hash goes
// through the bit-serial remainder unit (one dividend bit a cycle,
// filter_bits as divisor), then a store read and a bit test; a store size
// that is not a power of two adds a second remainder pass for the
// byte-address wrap. A clear first bit ends the query early.
// The filter store is one synchronous RAM with a registered read.
// Configuration (i_cfg_we/idx/data) must be written only while the engine
// is idle; the block itself does not enforce this.
// Reset clears both hashes, restores filter_bits and hash_count; the store
// keeps its contents and must be loaded before it is queried.
// A finished result sits in an output register; a stalled receiver holds it
// while new requests are accepted until the next result is ready.
module bloom_filter_membership_check_core #(
    parameter int MAX_FILTER_BYTES = 131072
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bfmc_in_if.sink                     i_req,
    bfmc_out_if.source                  o_res,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [bfmc_pkg::FB_W-1:0]   i_cfg_data
);

    localparam int AW = (MAX_FILTER_BYTES > 1) ? $clog2(MAX_FILTER_BYTES) : 1;
    localparam bit BYTE_POW2 = ((MAX_FILTER_BYTES & (MAX_FILTER_BYTES - 1)) == 0);
    localparam logic [AW-1:0] ADDR_MASK = AW'(MAX_FILTER_BYTES - 1);
    localparam logic [bfmc_pkg::DIV_W-1:0] STORE_BYTES = bfmc_pkg::DIV_W'(MAX_FILTER_BYTES);

    bfmc_pkg::t_state               r_state, n_state;
    logic [bfmc_pkg::FB_W-1:0]      r_filter_bits;
    logic [bfmc_pkg::HC_W-1:0]      r_hash_count;
    logic [bfmc_pkg::HASH_W-1:0]    r_sax, n_sax;
    logic [bfmc_pkg::HASH_W-1:0]    r_sdbm, n_sdbm;
    logic [bfmc_pkg::HASH_W-1:0]    r_h_sdbm, n_h_sdbm;
    logic [bfmc_pkg::FB_W-1:0]      r_size, n_size;
    logic [bfmc_pkg::HC_W-1:0]      r_n, n_n;
    logic                           r_which, n_which;
    logic                           r_found_acc, n_found_acc;
    logic [2:0]                     r_bit_pos, n_bit_pos;
    logic [AW-1:0]                  r_rd_addr, n_rd_addr;
    logic [bfmc_pkg::BYTE_W-1:0]    r_load_data, n_load_data;
    logic [bfmc_pkg::BYTE_W-1:0]    r_rdata;
    logic                           r_out_valid;
    logic                           r_out_found;

    logic                           in_acc;
    logic                           out_load;
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [bfmc_pkg::BYTE_W-1:0]    mem_wdata;
    logic [bfmc_pkg::HASH_W-1:0]    kb;
    logic [bfmc_pkg::FB_W-1:0]      idx;
    logic [bfmc_pkg::FB_W-4:0]      byte_idx;
    logic [bfmc_pkg::HC_W-1:0]      hc_eff;
    logic [bfmc_pkg::FB_W-1:0]      size_eff;

    bfmc_pkg::t_mod_req             mod_req;
    bfmc_pkg::t_mod_rsp             mod_rsp;

    logic [bfmc_pkg::BYTE_W-1:0]    mem [MAX_FILTER_BYTES];

    bfmc_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    assign in_acc      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == bfmc_pkg::S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.found = r_out_found;

    assign kb       = bfmc_pkg::HASH_W'(i_req.key_byte);
    assign idx      = mod_rsp.rem[bfmc_pkg::FB_W-1:0];
    assign byte_idx = idx[bfmc_pkg::FB_W-1:3];
    assign hc_eff   = (r_hash_count > bfmc_pkg::HASH_COUNT_MAX) ?
                      bfmc_pkg::HASH_COUNT_MAX : r_hash_count;
    assign size_eff = (r_filter_bits == '0) ? bfmc_pkg::FB_W'(1) : r_filter_bits;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_bits <= bfmc_pkg::FILTER_BITS_RST;
            r_hash_count  <= bfmc_pkg::HASH_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bfmc_pkg::CFG_FILTER_BITS: r_filter_bits <= i_cfg_data;
                bfmc_pkg::CFG_HASH_COUNT:  r_hash_count  <= i_cfg_data[bfmc_pkg::HC_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer: next state, memory and remainder-unit control
    always_comb begin
        n_state     = r_state;
        n_sax       = r_sax;
        n_sdbm      = r_sdbm;
        n_h_sdbm    = r_h_sdbm;
        n_size      = r_size;
        n_n         = r_n;
        n_which     = r_which;
        n_found_acc = r_found_acc;
        n_bit_pos   = r_bit_pos;
        n_rd_addr   = r_rd_addr;
        n_load_data = r_load_data;
        out_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = AW'(i_req.load_addr) & ADDR_MASK;
        mem_wdata   = i_req.load_data;
        mod_req.start    = 1'b0;
        mod_req.dividend = r_h_sdbm;
        mod_req.divisor  = bfmc_pkg::DIV_W'(r_size);

        unique case (r_state)
            bfmc_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (i_req.cmd)
                        bfmc_pkg::CMD_LOAD: begin
                            if (BYTE_POW2) begin
                                mem_we = 1'b1;
                            end else begin
                                mod_req.start    = 1'b1;
                                mod_req.dividend = bfmc_pkg::HASH_W'(i_req.load_addr);
                                mod_req.divisor  = STORE_BYTES;
                                n_load_data      = i_req.load_data;
                                n_state          = bfmc_pkg::S_LOAD_MOD;
                            end
                        end
                        bfmc_pkg::CMD_KEY: begin
                            if (i_req.key_byte != '0) begin
                                n_sax  = r_sax ^ ((r_sax << 5) + (r_sax >> 2) + kb);
                                n_sdbm = kb + (r_sdbm << 6) + (r_sdbm << 16) - r_sdbm;
                            end
                        end
                        bfmc_pkg::CMD_QUERY: begin
                            n_sax       = '0;
                            n_sdbm      = '0;
                            n_h_sdbm    = r_sdbm;
                            n_size      = size_eff;
                            n_n         = hc_eff;
                            n_which     = 1'b0;
                            n_found_acc = 1'b1;
                            if (hc_eff == '0) begin
                                n_state = bfmc_pkg::S_DONE;
                            end else begin
                                mod_req.start    = 1'b1;
                                mod_req.dividend = r_sax;
                                mod_req.divisor  = bfmc_pkg::DIV_W'(size_eff);
                                n_state          = bfmc_pkg::S_HASH_MOD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            bfmc_pkg::S_LOAD_MOD: begin
                if (mod_rsp.done) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(mod_rsp.rem);
                    mem_wdata = r_load_data;
                    n_state   = bfmc_pkg::S_IDLE;
                end
            end
            bfmc_pkg::S_HASH_MOD: begin
                if (mod_rsp.done) begin
                    n_bit_pos = idx[2:0];
                    if (BYTE_POW2) begin
                        n_rd_addr = AW'(byte_idx) & ADDR_MASK;
                        n_state   = bfmc_pkg::S_READ;
                    end else begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = bfmc_pkg::HASH_W'(byte_idx);
                        mod_req.divisor  = STORE_BYTES;
                        n_state          = bfmc_pkg::S_BYTE_MOD;
                    end
                end
            end
            bfmc_pkg::S_BYTE_MOD: begin
                if (mod_rsp.done) begin
                    n_rd_addr = AW'(mod_rsp.rem);
                    n_state   = bfmc_pkg::S_READ;
                end
            end
            bfmc_pkg::S_READ: begin
                n_state = bfmc_pkg::S_TEST;
            end
            bfmc_pkg::S_TEST: begin
                if (!r_rdata[r_bit_pos]) begin
                    n_found_acc = 1'b0;
                    n_state     = bfmc_pkg::S_DONE;
                end else if (!r_which && (r_n == bfmc_pkg::HASH_COUNT_MAX)) begin
                    // second hash: SDBM
                    mod_req.start = 1'b1;
                    n_which       = 1'b1;
                    n_state       = bfmc_pkg::S_HASH_MOD;
                end else begin
                    n_state = bfmc_pkg::S_DONE;
                end
            end
            bfmc_pkg::S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = bfmc_pkg::S_IDLE;
                end
            end
            default: n_state = bfmc_pkg::S_IDLE;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfmc_pkg::S_IDLE;
            r_sax       <= '0;
            r_sdbm      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sax   <= n_sax;
            r_sdbm  <= n_sdbm;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // query working registers
    always_ff @(posedge i_clk) begin
        r_h_sdbm    <= n_h_sdbm;
        r_size      <= n_size;
        r_n         <= n_n;
        r_which     <= n_which;
        r_found_acc <= n_found_acc;
        r_bit_pos   <= n_bit_pos;
        r_rd_addr   <= n_rd_addr;
        r_load_data <= n_load_data;
        if (out_load) begin
            r_out_found <= r_found_acc;
        end
    end

    // filter store: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[r_rd_addr];
    end

    // checks
    a_query_clears_hashes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_req.cmd == bfmc_pkg::CMD_QUERY)) |=> (r_sax == '0) && (r_sdbm == '0))
        else $error("hashes not cleared after end of key");

    a_mod_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_rsp.done |-> ((r_state == bfmc_pkg::S_LOAD_MOD) ||
                          (r_state == bfmc_pkg::S_HASH_MOD) ||
                          (r_state == bfmc_pkg::S_BYTE_MOD)))
        else $error("remainder finished with nobody waiting");

    a_test_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bfmc_pkg::S_TEST) |-> ($past(r_state) == bfmc_pkg::S_READ))
        else $error("bit tested without a store read");

    a_no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_req.start |-> !mod_rsp.busy)
        else $error("remainder unit restarted while busy");

endmodule

### tb/tb_bloom_filter_membership_check_core.sv
module tb_bloom_filter_membership_check_core;
    import bfmc_pkg::*;

    localparam int MEM_BYTES    = 131072;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 72;
    localparam int SETTLE       = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    // How a query's tested bytes are prepared before the query goes out
    typedef enum int {
        PLANT_ALL_SET,
        PLANT_FIRST_CLEAR,
        PLANT_SECOND_CLEAR,
        PLANT_AS_IS
    } t_plant;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [FB_W-1:0] i_cfg_data;

    bfmc_in_if  req_if ();
    bfmc_out_if res_if ();

    bloom_filter_membership_check_core #(
        .MAX_FILTER_BYTES (MEM_BYTES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Mirror of the filter store, both hashes and the settings; queues found bits
    class bloom_found_scoreboard;
        bit [7:0]        filter_mem [MEM_BYTES];
        bit              written [MEM_BYTES];
        bit [HASH_W-1:0] sax_h;
        bit [HASH_W-1:0] sdbm_h;
        bit [FB_W-1:0]   size_reg;
        bit [HC_W-1:0]   count_reg;
        bit              pending_found [$];
        int              errors;
        int              queries;
        int              hits;

        function new();
            size_reg  = FILTER_BITS_RST;
            count_reg = HASH_COUNT_RST;
        endfunction

        function void write_reg(logic idx, logic [FB_W-1:0] val);
            if (idx == CFG_FILTER_BITS) size_reg = val;
            else count_reg = val[HC_W-1:0];
        endfunction

        function int hashes_tested();
            return (count_reg > HASH_COUNT_MAX) ? int'(HASH_COUNT_MAX) : int'(count_reg);
        endfunction

        function bit [31:0] bit_index(bit [HASH_W-1:0] h);
            bit [31:0] size;
            size = (size_reg == 0) ? 32'd1 : 32'(size_reg);
            return h % size;
        endfunction

        function int byte_of(bit [HASH_W-1:0] h);
            return int'((bit_index(h) >> 3) % MEM_BYTES);
        endfunction

        function bit filter_bit(bit [HASH_W-1:0] h);
            bit [31:0] idx;
            idx = bit_index(h);
            return filter_mem[byte_of(h)][idx[2:0]];
        endfunction

        function void mismatch(string msg);
            errors++;
            if (errors <= 10) $display("%0t: %s", $realtime, msg);
        endfunction

        // Apply one accepted request
        function void note_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                   logic [BYTE_W-1:0] data, logic [BYTE_W-1:0] kb);
            bit [HASH_W-1:0] k;
            bit              f;
            int              n;
            k = HASH_W'(kb);
            case (cmd)
                CMD_LOAD: begin
                    filter_mem[int'(addr) % MEM_BYTES] = data;
                    written[int'(addr) % MEM_BYTES]    = 1'b1;
                end
                CMD_KEY: begin
                    if (kb != 0) begin
                        sax_h  = sax_h ^ ((sax_h << 5) + (sax_h >> 2) + k);
                        sdbm_h = k + (sdbm_h << 6) + (sdbm_h << 16) - sdbm_h;
                    end
                end
                CMD_QUERY: begin
                    n = hashes_tested();
                    f = 1'b1;
                    if (n >= 1 && !filter_bit(sax_h)) f = 1'b0;
                    if (f && n >= 2 && !filter_bit(sdbm_h)) f = 1'b0;
                    pending_found.push_back(f);
                    sax_h  = '0;
                    sdbm_h = '0;
                    queries++;
                    if (f) hits++;
                end
                default: ;
            endcase
        endfunction

        function void check_found(logic actual);
            bit want;
            if (pending_found.size() == 0) begin
                mismatch($sformatf("result with none pending: found=%b", actual));
                return;
            end
            want = pending_found.pop_front();
            if (actual !== want)
                mismatch($sformatf("found mismatch: expected %b, got %b", want, actual));
        endfunction
    endclass

    bloom_found_scoreboard sb = new();

    bit no_idle;
    bit hold_results;
    int items_sent;
    int holds_done;

    int unsigned phase_bits  [PHASES] = '{1048576, 1, 0, 2097151, 1048576,
                                          1048575, 12, 0, 1048576};
    int unsigned phase_count [PHASES] = '{2, 1, 2, 2, 0, 3, 2, 1, 2};

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result receiver
    initial begin
        int stall;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_results = 1'b0;
                holds_done++;
            end else if (no_idle) begin
                res_if.ready <= 1'b1;
            end else begin
                stall = idle_len();
                if (stall == 0) begin
                    res_if.ready <= 1'b1;
                end else begin
                    res_if.ready <= 1'b0;
                    repeat (stall - 1) @(negedge i_clk);
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) sb.check_found(res_if.found);
    end

    // Offer one request and wait for it to be taken
    task automatic send_request(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
                                logic [BYTE_W-1:0] d, logic [BYTE_W-1:0] k);
        @(negedge i_clk);
        req_if.valid     <= 1'b1;
        req_if.cmd       <= c;
        req_if.load_addr <= a;
        req_if.load_data <= d;
        req_if.key_byte  <= k;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        sb.note_request(c, a, d, k);
        if (c != CMD_SPARE && !(c == CMD_KEY && k == 0)) items_sent++;
    endtask

    task automatic rest();
        int n;
        n = no_idle ? 0 : idle_len();
        if (n > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_load(logic [ADDR_W-1:0] a, logic [BYTE_W-1:0] d);
        send_request(CMD_LOAD, a, d, BYTE_W'($urandom));
        rest();
    endtask

    task automatic send_key(logic [BYTE_W-1:0] k);
        send_request(CMD_KEY, ADDR_W'($urandom), BYTE_W'($urandom), k);
        rest();
    endtask

    // Load the tested bytes as the chosen plan needs, then end the key
    task automatic issue_query();
        t_plant          plan;
        bit [HASH_W-1:0] h;
        bit [31:0]       idx;
        bit [7:0]        cur;
        bit [7:0]        want;
        bit [7:0]        mask;
        int              a;
        plan = t_plant'($urandom_range(0, 3));
        for (int j = 0; j < sb.hashes_tested(); j++) begin
            h    = (j == 0) ? sb.sax_h : sb.sdbm_h;
            idx  = sb.bit_index(h);
            a    = sb.byte_of(h);
            mask = 8'd1 << idx[2:0];
            cur  = sb.written[a] ? sb.filter_mem[a] : 8'($urandom);
            case (plan)
                PLANT_ALL_SET:      want = cur | mask;
                PLANT_FIRST_CLEAR:  want = (j == 0) ? (cur & ~mask) : (cur | mask);
                PLANT_SECOND_CLEAR: want = (j == 1) ? (cur & ~mask) : (cur | mask);
                default:            want = cur;
            endcase
            if (!sb.written[a] || sb.filter_mem[a] != want) send_load(ADDR_W'(a), want);
        end
        send_request(CMD_QUERY, ADDR_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
        rest();
    endtask

    task automatic write_cfg(logic idx, logic [FB_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Stop offering and wait until every result is in and the engine settles
    task automatic drain();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (sb.pending_found.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_random(int target);
        int pick;
        int len;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                  : $urandom_range(0, 6);
                repeat (len) begin
                    if ($urandom_range(0, 9) == 0) send_load(ADDR_W'($urandom), 8'($urandom));
                    send_key(8'($urandom_range(1, 255)));
                end
                // an abandoned fragment runs on into the next key
                if (pick < 72) issue_query();
            end else if (pick < 90) begin
                send_load(ADDR_W'($urandom), 8'($urandom));
            end else if (pick < 95) begin
                send_request(CMD_SPARE, ADDR_W'($urandom), 8'($urandom), 8'($urandom));
                rest();
            end else begin
                send_key(8'd0);
            end
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= 1'b0;
        i_cfg_data       <= '0;
        req_if.valid     <= 1'b0;
        req_if.cmd       <= CMD_LOAD;
        req_if.load_addr <= '0;
        req_if.load_data <= '0;
        req_if.key_byte  <= '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: store extremes, empty key, key byte extremes, ignored items
        send_load(17'd0, 8'hFF);
        send_load(17'h1FFFF, 8'h00);
        send_load(17'h15555, 8'hA5);
        send_load(17'h0AAAA, 8'h5A);
        send_request(CMD_QUERY, '0, '0, '0);
        rest();
        send_key(8'hFF);
        issue_query();
        send_key(8'h01);
        send_key(8'h00);
        send_request(CMD_SPARE, 17'h1FFFF, 8'hFF, 8'hFF);
        rest();
        send_key(8'h80);
        issue_query();
        send_key(8'h7F);
        send_key(8'hAA);
        send_key(8'h55);
        send_key(8'hFE);
        issue_query();

        // Random phases, one filter setting each
        for (int p = 0; p < PHASES; p++) begin
            drain();
            if (p == 7) phase_bits[p] = $urandom_range(1, 2097151);
            write_cfg(CFG_FILTER_BITS, FB_W'(phase_bits[p]));
            write_cfg(CFG_HASH_COUNT, FB_W'(phase_count[p]));
            no_idle = (p == 2 || p == 6 || p == 8);
            if (p == 8) hold_results = 1'b1;
            if (p == 5) begin
                run_random(items_sent + PHASE_ITEMS / 2);
                drain();
            end
            run_random(items_sent + PHASE_ITEMS);
        end
        no_idle = 1'b0;
        drain();

        $display("Run covered %0d requests, %0d queries (%0d found) over %0d filter settings,",
                 items_sent, sb.queries, sb.hits, PHASES + 1);
        $display("with random gaps, %0d long result hold-off(s) and full drains between phases.",
                 holds_done);
        if (sb.errors == 0 && sb.pending_found.size() == 0) begin
            $display("tb_bloom_filter_membership_check_core: PASS");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("tb_bloom_filter_membership_check_core: FAIL");
        end
        $finish;
    end

    // Overall time limit
    initial begin
        #4000000;
        $display("timeout with %0d results pending", sb.pending_found.size());
        $display("tb_bloom_filter_membership_check_core: FAIL");
        $finish;
    end

endmodule

### files.f
design/bfmc_pkg.sv
design/bfmc_in_if.sv
design/bfmc_out_if.sv
design/bfmc_mod.sv
design/bloom_filter_membership_check_core.sv
tb/tb_bloom_filter_membership_check_core.sv
